// ----- rtl/colormap_gradient_lerp_defines.svh -----
// Assertion macros for the colour map block.
`ifndef COLORMAP_GRADIENT_LERP_DEFINES_SVH
`define COLORMAP_GRADIENT_LERP_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk_i, quiet during reset.
`define CGL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, sampled on clk_i, quiet during reset.
`define CGL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CGL_ASSERT_NOW(lbl, ante, cons)
`define CGL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/cgl_pkg.sv -----
package cgl_pkg;

  localparam int PALETTE_DEPTH = 16;
  localparam int FRACTION_BITS = 16;
  localparam int IDX_W         = $clog2(PALETTE_DEPTH);
  localparam int QUO_W         = IDX_W + FRACTION_BITS;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 2'd2;

  localparam logic ACTION_MAP   = 1'b0;
  localparam logic ACTION_WRITE = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] sample;
    logic [3:0]  entry_index;
    logic [7:0]  entry_red;
    logic [7:0]  entry_green;
    logic [7:0]  entry_blue;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       range_error;
  } out_rsp_t;

endpackage

// ----- rtl/cgl_palette.sv -----
module cgl_palette (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [cgl_pkg::IDX_W-1:0] waddr_i,
  input  logic [23:0]              wdata_i,
  input  logic [cgl_pkg::IDX_W-1:0] raddr_a_i,
  input  logic [cgl_pkg::IDX_W-1:0] raddr_b_i,
  output logic [23:0]              rdata_a_o,
  output logic [23:0]              rdata_b_o
);
  import cgl_pkg::*;

  logic [23:0] mem [PALETTE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Hold read data while stalled.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

// ----- rtl/colormap_gradient_lerp.sv -----
// Channel  | Direction | Handshake               | Payload
// request  | in        | in_valid_i / in_ready_o | in_req_i   (cgl_pkg::in_req_t)
// result   | out       | out_valid_o/out_ready_i | out_rsp_o  (cgl_pkg::out_rsp_t)
// config   | in        | cfg_we_i, no wait       | cfg_idx_i, cfg_data_i
//
// One request per cycle while the pipeline advances; a map request's colour passes through
// setup, multiply, one quotient bit per divider stage, palette read, then the blend into
// the output register.
// The whole pipeline advances together while the output register is empty or being
// taken; otherwise everything holds and in_ready_o drops.
// Palette writes travel the pipeline and land at the read stage, so order holds.
// Reset clears valid flags and loads register defaults; the palette is not cleared.
`include "colormap_gradient_lerp_defines.svh"
module colormap_gradient_lerp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  cgl_pkg::in_req_t                 in_req_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output cgl_pkg::out_rsp_t                out_rsp_o,
  input  logic                             cfg_we_i,
  input  logic [cgl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [31:0]                      cfg_data_i
);
  import cgl_pkg::*;

  localparam int F = FRACTION_BITS;

  // One record per pipeline slot; rem doubles as diff, then partial remainder.
  typedef struct packed {
    logic             vld;
    logic             wr;
    logic             err;
    logic             interp;
    logic [IDX_W-1:0] addr;
    logic [3:0]       widx;
    logic [23:0]      rgb;
    logic [31:0]      span;
    logic [31:0]      rem;
    logic [QUO_W-1:0] nb;
    logic [QUO_W-1:0] q;
  } pipe_t;

  typedef struct packed {
    logic         vld;
    logic         wr;
    logic         err;
    logic [F-1:0] frac;
  } rd_t;

  logic [31:0] min_q, max_q;
  logic [4:0]  entries_q;

  pipe_t s0_q, s1_q;
  pipe_t dv_q [QUO_W];
  rd_t   rd_q;
  logic  out_vld_q;
  out_rsp_t out_q;
  logic  pipe_en;

  assign pipe_en     = !out_vld_q || out_ready_i;
  assign in_ready_o  = pipe_en;
  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q     <= 32'd0;
      max_q     <= 32'd255;
      entries_q <= 5'd2;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RANGE_MIN:      min_q     <= cfg_data_i;
        CFG_RANGE_MAX:      max_q     <= cfg_data_i;
        CFG_ENTRIES_IN_USE: entries_q <= cfg_data_i[4:0];
        default:            ;
      endcase
    end
  end

  // Setup: classify the sample against the range.
  pipe_t s0_d;
  logic [8:0] n_sat;
  logic signed [32:0] diff, span;
  always_comb begin
    n_sat = (entries_q == 5'd0) ? 9'd1 : {4'd0, entries_q};
    if (n_sat > 9'(PALETTE_DEPTH)) n_sat = 9'(PALETTE_DEPTH);
    diff = $signed({in_req_i.sample[31], in_req_i.sample}) - $signed({min_q[31], min_q});
    span = $signed({max_q[31], max_q}) - $signed({min_q[31], min_q});
    s0_d        = '0;
    s0_d.vld    = in_valid_i;
    s0_d.wr     = (in_req_i.action == ACTION_WRITE);
    s0_d.widx   = in_req_i.entry_index;
    s0_d.rgb    = {in_req_i.entry_red, in_req_i.entry_green, in_req_i.entry_blue};
    s0_d.span   = span[31:0];
    s0_d.rem    = diff[31:0];
    if ($signed(max_q) <= $signed(min_q)) begin
      s0_d.err  = 1'b1;
      s0_d.addr = '0;
    end else if (n_sat == 9'd1 || diff >= span) begin
      s0_d.addr = IDX_W'(n_sat - 9'd1);
    end else if (diff <= 33'sd0) begin
      s0_d.addr = '0;
    end else begin
      s0_d.interp = 1'b1;
      s0_d.addr   = IDX_W'(n_sat - 9'd1);
    end
  end

  // Multiply: p = diff * last, then seed the divider with p >> IDX_W.
  pipe_t s1_d;
  logic [31+IDX_W:0] prod;
  always_comb begin
    prod    = (32+IDX_W)'(s0_q.rem) * (32+IDX_W)'(s0_q.addr);
    s1_d     = s0_q;
    s1_d.rem = prod[31+IDX_W:IDX_W];
    s1_d.nb  = {prod[IDX_W-1:0], {F{1'b0}}};
    s1_d.q   = '0;
  end

  function automatic pipe_t div_step(input pipe_t p);
    pipe_t       r;
    logic [32:0] t;
    r = p;
    t = {p.rem, p.nb[QUO_W-1]};
    if (t >= {1'b0, p.span}) begin
      r.rem = 32'(t - {1'b0, p.span});
      r.q   = {p.q[QUO_W-2:0], 1'b1};
    end else begin
      r.rem = t[31:0];
      r.q   = {p.q[QUO_W-2:0], 1'b0};
    end
    r.nb = {p.nb[QUO_W-2:0], 1'b0};
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q.vld <= 1'b0;
      s1_q.vld <= 1'b0;
      for (int k = 0; k < QUO_W; k++) dv_q[k].vld <= 1'b0;
    end else if (pipe_en) begin
      s0_q     <= s0_d;
      s1_q     <= s1_d;
      dv_q[0]  <= div_step(s1_q);
      for (int k = 1; k < QUO_W; k++) dv_q[k] <= div_step(dv_q[k-1]);
    end
  end

  // Palette access: writes commit here, interpolating maps read two neighbouring entries.
  pipe_t dl;
  logic [IDX_W-1:0] ra, rb;
  logic             mem_we;
  logic [23:0]      lo_rgb, hi_rgb;
  rd_t              rd_d;
  assign dl = dv_q[QUO_W-1];
  always_comb begin
    ra     = dl.interp ? dl.q[QUO_W-1:F] : dl.addr;
    rb     = dl.interp ? IDX_W'(dl.q[QUO_W-1:F] + 1'b1) : dl.addr;
    mem_we = dl.vld && dl.wr && ({5'd0, dl.widx} < 9'(PALETTE_DEPTH));
    rd_d.vld  = dl.vld;
    rd_d.wr   = dl.wr;
    rd_d.err  = dl.err;
    rd_d.frac = dl.interp ? dl.q[F-1:0] : '0;
  end

  cgl_palette u_palette (
    .clk_i     (clk_i),
    .en_i      (pipe_en),
    .we_i      (mem_we),
    .waddr_i   (IDX_W'(dl.widx)),
    .wdata_i   (dl.rgb),
    .raddr_a_i (ra),
    .raddr_b_i (rb),
    .rdata_a_o (lo_rgb),
    .rdata_b_o (hi_rgb)
  );

  function automatic logic [7:0] blend(input logic [7:0] lo, input logic [7:0] hi,
                                       input logic [F-1:0] f);
    logic [F:0]    w;
    logic [F+9:0]  acc;
    w   = (F+1)'(1) << F;
    w   = w - (F+1)'(f);
    acc = (F+10)'(lo) * (F+10)'(w) + (F+10)'(hi) * (F+10)'(f);
    return acc[F+7:F];
  endfunction

  out_rsp_t out_d;
  always_comb begin
    out_d.out_red     = blend(lo_rgb[23:16], hi_rgb[23:16], rd_q.frac);
    out_d.out_green   = blend(lo_rgb[15:8],  hi_rgb[15:8],  rd_q.frac);
    out_d.out_blue    = blend(lo_rgb[7:0],   hi_rgb[7:0],   rd_q.frac);
    out_d.range_error = rd_q.err;
  end

  // Drop write requests at the output; present map results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q.vld  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (pipe_en) begin
      rd_q      <= rd_d;
      out_vld_q <= rd_q.vld && !rd_q.wr;
      out_q     <= out_d;
    end
  end

  `CGL_ASSERT_NOW(a_idx_below_last, dl.vld && dl.interp, dl.q[QUO_W-1:F] < dl.addr)
  `CGL_ASSERT_NEXT(a_stall_holds_div, !pipe_en, $stable(dl) && $stable(rd_q))

endmodule

// ----- dv/colormap_gradient_lerp_tb.sv -----
module colormap_gradient_lerp_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cgl_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_req_t              in_req = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_rsp_t             out_rsp;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_RANGE_MIN;
  logic [31:0]          cfg_data = '0;

  colormap_gradient_lerp u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always #10 clk_i = ~clk_i;

  // Covers the pipeline depth plus margin; palette writes give no
  // result, so wait this long before touching a register.
  localparam int SETTLE_CYCLES = QUO_W + 20;

  // Shadow copy of the block's registers and palette.
  int          range_lo;
  int          range_hi;
  logic [4:0]  active_entries;
  logic [23:0] palette_shadow [PALETTE_DEPTH];

  out_rsp_t expected_colours[$];
  int       fail_count = 0;
  bit       calm = 1'b0;   // no idling on either side while set

  typedef struct {
    bit          has_cfg;
    logic [1:0]  cfg_sel;
    logic [31:0] cfg_val;
    in_req_t     req;
    bit          typed;
    out_rsp_t    want;
  } step_t;

  step_t steps[$];

  // Work out the colour a map request must give under the current settings.
  function automatic out_rsp_t predict_colour(input logic [31:0] smp);
    int unsigned       n, last_e, seg;
    longint            diff, span;
    longint unsigned   p, s, rem, f, lo, hi, one;
    logic [23:0]       lo_c, hi_c, colour;
    out_rsp_t          r;
    n = active_entries;
    if (n == 0) n = 1;
    if (n > PALETTE_DEPTH) n = PALETTE_DEPTH;
    last_e = n - 1;
    r.range_error = 1'b0;
    if (range_hi <= range_lo) begin
      colour = palette_shadow[0];
      r.range_error = 1'b1;
    end else begin
      span = longint'(range_hi) - longint'(range_lo);
      diff = longint'(signed'(smp)) - longint'(range_lo);
      if (last_e == 0 || diff >= span) begin
        colour = palette_shadow[last_e];
      end else if (diff <= 0) begin
        colour = palette_shadow[0];
      end else begin
        p   = longint'(diff) * longint'(last_e);
        s   = span;
        seg = p / s;
        rem = p % s;
        f   = (rem << FRACTION_BITS) / s;
        if (seg >= last_e) begin
          colour = palette_shadow[last_e];
        end else begin
          one  = longint'(1) << FRACTION_BITS;
          lo_c = palette_shadow[seg];
          hi_c = palette_shadow[seg + 1];
          for (int c = 0; c < 3; c++) begin
            lo = lo_c[23 - 8*c -: 8];
            hi = hi_c[23 - 8*c -: 8];
            colour[23 - 8*c -: 8] = 8'((lo * (one - f) + hi * f) >> FRACTION_BITS);
          end
        end
      end
    end
    {r.out_red, r.out_green, r.out_blue} = colour;
    return r;
  endfunction

  function automatic in_req_t map_req(input logic [31:0] smp);
    in_req_t r;
    r = '0;
    r.action = ACTION_MAP;
    r.sample = smp;
    return r;
  endfunction

  function automatic in_req_t write_req(input logic [3:0] idx, input logic [23:0] rgb);
    in_req_t r;
    r = '0;
    r.action = ACTION_WRITE;
    r.entry_index = idx;
    {r.entry_red, r.entry_green, r.entry_blue} = rgb;
    return r;
  endfunction

  function automatic out_rsp_t colour_of(input logic [23:0] rgb, input logic err);
    out_rsp_t r;
    {r.out_red, r.out_green, r.out_blue} = rgb;
    r.range_error = err;
    return r;
  endfunction

  function automatic void add_step(input bit has_cfg, input logic [1:0] sel,
                                   input logic [31:0] val, input in_req_t req,
                                   input bit typed, input out_rsp_t want);
    step_t st;
    st.has_cfg = has_cfg;
    st.cfg_sel = sel;
    st.cfg_val = val;
    st.req     = req;
    st.typed   = typed;
    st.want    = want;
    steps.push_back(st);
  endfunction

  // Hand one request over; returns at the edge where it was accepted.
  task automatic send_request(input in_req_t r);
    if (!calm && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // Account for an accepted request in the shadow state and the expectations.
  task automatic book_request(input in_req_t r, input bit typed, input out_rsp_t want);
    if (r.action == ACTION_WRITE) begin
      palette_shadow[r.entry_index] = {r.entry_red, r.entry_green, r.entry_blue};
    end else if (typed) begin
      expected_colours.push_back(want);
    end else begin
      expected_colours.push_back(predict_colour(r.sample));
    end
  endtask

  // Drop valid and wait until the pipeline is empty before a register write.
  task automatic drain;
    in_valid <= 1'b0;
    while (expected_colours.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Leaves cfg_we high; the caller lowers it after its last write.
  task automatic write_reg(input logic [1:0] sel, input logic [31:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= sel;
    cfg_data <= val;
    @(posedge clk_i);
    case (sel)
      CFG_RANGE_MIN:      range_lo = val;
      CFG_RANGE_MAX:      range_hi = val;
      CFG_ENTRIES_IN_USE: active_entries = val[4:0];
      default: ;
    endcase
  endtask

  // Result side: random back-pressure, except in the calm stretch.
  always @(posedge clk_i) begin
    out_ready <= calm || ($urandom_range(99) >= 35);
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    out_rsp_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_colours.size() == 0) begin
        $error("unexpected result %h", out_rsp);
        fail_count++;
      end else begin
        want = expected_colours.pop_front();
        if (out_rsp.out_red !== want.out_red) begin
          $error("out_red exp %0h got %0h", want.out_red, out_rsp.out_red);
          fail_count++;
        end
        if (out_rsp.out_green !== want.out_green) begin
          $error("out_green exp %0h got %0h", want.out_green, out_rsp.out_green);
          fail_count++;
        end
        if (out_rsp.out_blue !== want.out_blue) begin
          $error("out_blue exp %0h got %0h", want.out_blue, out_rsp.out_blue);
          fail_count++;
        end
        if (out_rsp.range_error !== want.range_error) begin
          $error("range_error exp %0h got %0h", want.range_error, out_rsp.range_error);
          fail_count++;
        end
      end
    end
  end

  // Hard stop in case the handshake locks up.
  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    in_req_t   r;
    out_rsp_t  none;
    longint    span, pick;
    logic [31:0] smp;
    none = '0;
    range_lo = 0;
    range_hi = 255;
    active_entries = 5'd2;
    foreach (palette_shadow[i]) palette_shadow[i] = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the upper palette first so no read ever hits an unwritten slot.
    for (int i = 2; i < PALETTE_DEPTH; i++) begin
      r = write_req(i[3:0], 24'($urandom));
      send_request(r);
      book_request(r, 1'b0, none);
    end

    // Directed table: the reset range (0..255) over two entries first, then
    // reversed/empty ranges, entry counts at and beyond the limits, full range.
    add_step(0, CFG_RANGE_MIN, 0, write_req(4'd0, 24'h000000), 0, none);
    add_step(0, CFG_RANGE_MIN, 0, write_req(4'd1, 24'hffffff), 0, none);
    add_step(0, CFG_RANGE_MIN, 0, map_req(32'd0), 1, colour_of(24'h000000, 0));
    add_step(0, CFG_RANGE_MIN, 0, map_req(32'd255), 1, colour_of(24'hffffff, 0));
    add_step(0, CFG_RANGE_MIN, 0, map_req(32'h8000_0000), 1, colour_of(24'h000000, 0));
    add_step(0, CFG_RANGE_MIN, 0, map_req(32'h7fff_ffff), 1, colour_of(24'hffffff, 0));
    add_step(0, CFG_RANGE_MIN, 0, map_req(32'd128), 0, none);
    add_step(0, CFG_RANGE_MIN, 0, map_req(32'd1), 0, none);
    add_step(0, CFG_RANGE_MIN, 0, map_req(32'd254), 0, none);
    add_step(1, CFG_RANGE_MAX, 32'd0, map_req(32'd50), 1, colour_of(24'h000000, 1));
    add_step(1, CFG_RANGE_MAX, -32'sd5, map_req(32'd7), 1, colour_of(24'h000000, 1));
    add_step(1, CFG_RANGE_MAX, 32'd255, map_req(32'd100), 0, none);
    add_step(1, CFG_ENTRIES_IN_USE, 32'd1, map_req(32'd100), 1, colour_of(24'h000000, 0));
    add_step(1, CFG_ENTRIES_IN_USE, 32'd0, map_req(32'd200), 1, colour_of(24'h000000, 0));
    add_step(1, CFG_ENTRIES_IN_USE, 32'd16, map_req(32'd128), 0, none);
    add_step(1, CFG_ENTRIES_IN_USE, 32'd31, map_req(32'd255), 0, none);
    add_step(1, CFG_RANGE_MIN, 32'h8000_0000, map_req(32'd0), 0, none);
    add_step(1, CFG_RANGE_MAX, 32'h7fff_ffff, map_req(32'h7fff_ffff), 0, none);
    add_step(0, CFG_RANGE_MIN, 0, map_req(32'h8000_0000), 0, none);
    add_step(0, CFG_RANGE_MIN, 0, write_req(4'd15, 24'ha55ac3), 0, none);
    add_step(0, CFG_RANGE_MIN, 0, map_req(32'h7fff_ffff), 0, none);

    foreach (steps[i]) begin
      if (steps[i].has_cfg) begin
        drain();
        write_reg(steps[i].cfg_sel, steps[i].cfg_val);
        cfg_we <= 1'b0;
      end
      send_request(steps[i].req);
      book_request(steps[i].req, steps[i].typed, steps[i].want);
    end

    // Random phases, each under fresh settings; phase 2 runs without idling.
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      calm = (ph == 2);
      case ($urandom_range(0, 5))
        0: begin
          write_reg(CFG_RANGE_MIN, 32'h8000_0000);
          write_reg(CFG_RANGE_MAX, 32'h7fff_ffff);
        end
        1: begin
          write_reg(CFG_RANGE_MAX, $urandom);
          write_reg(CFG_RANGE_MIN, range_hi - $urandom_range(0, 3));
        end
        2: begin
          write_reg(CFG_RANGE_MIN, $urandom);
          write_reg(CFG_RANGE_MAX, $urandom);
        end
        default: begin
          write_reg(CFG_RANGE_MIN, $urandom);
          pick = longint'(range_lo) + $urandom_range(1, 5000);
          if (pick > 64'sd2147483647) pick = 64'sd2147483647;
          write_reg(CFG_RANGE_MAX, 32'(pick));
        end
      endcase
      write_reg(CFG_ENTRIES_IN_USE, ($urandom_range(3) == 0) ? $urandom_range(0, 31)
                                                               : $urandom_range(2, 16));
      cfg_we <= 1'b0;

      for (int k = 0; k < 125; k++) begin
        if ($urandom_range(99) < 25) begin
          r = write_req(4'($urandom_range(0, 15)), 24'($urandom));
        end else begin
          span = longint'(range_hi) - longint'(range_lo);
          if (span <= 0 || $urandom_range(99) < 20) begin
            smp = $urandom;
          end else begin
            // Land mostly inside the range, a little either side of it.
            pick = longint'(range_lo) - span / 8
                 + ((longint'($urandom >> 8) * (span + span / 4 + 1)) >>> 24);
            if (pick > 64'sd2147483647) pick = 64'sd2147483647;
            if (pick < -64'sd2147483648) pick = -64'sd2147483648;
            smp = 32'(pick);
          end
          r = map_req(smp);
        end
        send_request(r);
        book_request(r, 1'b0, none);
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
